// File: hdl/sensor_word_crc8_frame_checker_unit_macros.svh
// Assertion macros for the sensor word CRC-8 frame checker.
// Used by the top level; needs nothing else.
`ifndef SENSOR_WORD_CRC8_FRAME_CHECKER_UNIT_MACROS_SVH
`define SENSOR_WORD_CRC8_FRAME_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWC8_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWC8_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/swc8fc_pkg.sv
// Package for the sensor word CRC-8 frame checker: constants and the CRC byte update.
// No dependencies.
`default_nettype none

package swc8fc_pkg;

  localparam int          FRAME_WORDS_DEF = 2;
  localparam logic [7:0]  CRC_POLY        = 8'h31;
  localparam logic [7:0]  CRC_INIT        = 8'hFF;
  localparam int          IN_TDATA_W      = 8;
  localparam int          OUT_TDATA_W     = 40;

  // Byte phase within one word.
  typedef enum logic [1:0] {
    POS_HIGH = 2'd0,
    POS_LOW  = 2'd1,
    POS_CRC  = 2'd2
  } byte_pos_t;

  // MSB-first CRC-8 over one byte, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sensor_word_crc8_frame_checker_unit.sv
// The result item appears on m_axis in the cycle after the CRC byte of the last word is taken.
// Throughput: one byte item per cycle while the input is not stalled; the CRC update is an unrolled eight-step
//   shift/xor between the input handshake and the state registers.
// Input stalls only when a result waits unread and the unit sits at the CRC byte of
//   the last word (a byte with frame_start set waits there too).
// Reset (rst, synchronous, active high): byte phase and word index to zero, CRC to 0xFF,
//   CRC flags cleared, no result pending.
`default_nettype none

`include "sensor_word_crc8_frame_checker_unit_macros.svh"

module sensor_word_crc8_frame_checker_unit #(
  parameter int FRAME_WORDS = swc8fc_pkg::FRAME_WORDS_DEF  // 1..8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input items
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [swc8fc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic                               s_axis_tuser,  // frame_start
  // result items
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [swc8fc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
  // m_axis_tdata: [15:0] co2_value, [31:16] tvoc_value, [32] co2_crc_good,
  //               [33] tvoc_crc_good, [34] frame_status, [39:35] zero
);

  import swc8fc_pkg::*;

  localparam int WIDX_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(FRAME_WORDS - 1);

  // ---------------------------------------------------------------- state
  byte_pos_t                byte_pos, byte_pos_next;
  logic [WIDX_W-1:0]        word_idx, word_idx_next;
  logic [7:0]               running_crc, running_crc_next;
  logic [15:0]              words [FRAME_WORDS];   // payload, written before it is read
  logic [FRAME_WORDS-1:0]   crc_flags, crc_flags_next;

  // ---------------------------------------------------------------- input side
  logic       in_fire;
  logic       out_free;
  logic       frame_done;
  byte_pos_t  cur_pos;      // phase after frame_start is applied
  logic [WIDX_W-1:0] cur_idx;
  logic [7:0] data_byte;
  logic       crc_match;

  assign data_byte = s_axis_tdata[7:0];
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // A byte that could close the frame waits only while a result is still unread.
  assign s_axis_tready = out_free || !((byte_pos == POS_CRC) && (word_idx == LAST_WORD));
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cur_pos   = s_axis_tuser ? POS_HIGH : byte_pos;
  assign cur_idx   = s_axis_tuser ? '0 : word_idx;
  assign crc_match = (running_crc == data_byte);

  always_comb begin
    byte_pos_next    = cur_pos;
    word_idx_next    = cur_idx;
    running_crc_next = running_crc;
    crc_flags_next   = crc_flags;
    frame_done       = 1'b0;
    unique case (cur_pos)
      POS_HIGH: begin
        running_crc_next = crc8_byte(CRC_INIT, data_byte);
        byte_pos_next    = POS_LOW;
      end
      POS_LOW: begin
        running_crc_next = crc8_byte(running_crc, data_byte);
        byte_pos_next    = POS_CRC;
      end
      POS_CRC: begin
        crc_flags_next[cur_idx] = crc_match;
        running_crc_next        = CRC_INIT;
        byte_pos_next           = POS_HIGH;
        if (cur_idx == LAST_WORD) begin
          word_idx_next = '0;
          frame_done    = 1'b1;
        end else begin
          word_idx_next = cur_idx + WIDX_W'(1);
        end
      end
      default: begin
        byte_pos_next = POS_HIGH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= POS_HIGH;
      word_idx    <= '0;
      running_crc <= CRC_INIT;
      crc_flags   <= '0;
    end else if (in_fire) begin
      byte_pos    <= byte_pos_next;
      word_idx    <= word_idx_next;
      running_crc <= running_crc_next;
      crc_flags   <= crc_flags_next;
    end
  end

  // Word capture: high byte then low byte into the current slot.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (cur_pos == POS_HIGH) words[cur_idx][15:8] <= data_byte;
      if (cur_pos == POS_LOW)  words[cur_idx][7:0]  <= data_byte;
    end
  end

  // ---------------------------------------------------------------- result
  logic [15:0] co2_value, tvoc_value;
  logic        co2_good, tvoc_good, frame_status;

  // The last word's low byte is already in words[] when its CRC byte arrives.
  assign co2_value    = words[0];
  assign co2_good     = crc_flags_next[0];
  assign frame_status = !(&crc_flags_next);

  generate
    if (FRAME_WORDS > 1) begin : g_two
      assign tvoc_value = words[1];
      assign tvoc_good  = crc_flags_next[1];
    end else begin : g_one
      assign tvoc_value = '0;
      assign tvoc_good  = 1'b0;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire && frame_done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && frame_done) begin
      m_axis_tdata <= {5'd0, frame_status, tvoc_good, co2_good, tvoc_value, co2_value};
    end
  end

  // ---------------------------------------------------------------- checks
  `SWC8_ASSERT_NOW(a_stall_only_when_full, clk, rst, !s_axis_tready,
    m_axis_tvalid && !m_axis_tready, "input stalled with result register free")
  `SWC8_ASSERT_NEXT(a_done_restarts, clk, rst, in_fire && frame_done,
    m_axis_tvalid && byte_pos == POS_HIGH && word_idx == '0,
    "frame completion did not post result and restart")
  `SWC8_ASSERT_NEXT(a_start_to_low, clk, rst, in_fire && s_axis_tuser,
    byte_pos == POS_LOW, "frame start byte not taken as high byte")
  `SWC8_ASSERT_NOW(a_status_covers_first, clk, rst, m_axis_tvalid,
    m_axis_tdata[34] || m_axis_tdata[32], "good status with bad first word")

endmodule

`default_nettype wire
